@@ sv/fhte_pkg.sv @@
// shared types and constants for the firmware header tag walker
package fhte_pkg;

  localparam logic [31:0] HDR_MAGIC   = 32'h5244_4842;
  localparam logic [31:0] HDR_BASE    = 32'd8;
  localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_TAG0    = 32'd11;
  localparam logic [31:0] POS_ITEM0   = 32'd19;
  localparam logic [31:0] POS_MIN_OK  = 32'd12;

  localparam logic [31:0] TAG_FW_OFFSET  = 32'd1;
  localparam logic [31:0] TAG_RT_SIZE    = 32'd2;
  localparam logic [31:0] TAG_ERR_OFFSET = 32'd4;

  localparam int NUM_SLOTS = 3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_TAG_MISSING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_WALK  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  // per-slot control from the walker
  typedef struct packed {
    logic        en;     // a byte transaction is taken this cycle
    logic        set;    // item with this slot's tag completes its header
    logic        clear;  // last byte: back to reset state
    logic [32:0] start;  // first value byte position of the item
  } slot_ctl_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] firmware_offset;
    logic [31:0] rt_size;
    logic [31:0] error_record_offset;
  } result_t;

endpackage

@@ sv/fhte_slot.sv @@
// capture slot for the 4-byte value of one required tag
module fhte_slot
  import fhte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  slot_ctl_t   ctl,
  input  logic [31:0] pos,
  input  logic [7:0]  data_byte,
  output logic        found,
  output logic [31:0] value
);

  logic [32:0] vstart;
  logic [32:0] diff;
  logic        in_win;
  logic [31:0] captured;

  assign diff   = {1'b0, pos} - vstart;
  assign in_win = found && ({1'b0, pos} >= vstart) && (diff[32:2] == '0);

  // value including the byte of the current transaction
  always_comb begin
    value = captured;
    if (in_win) begin
      value[{diff[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      vstart   <= '0;
      captured <= '0;
    end else if (ctl.en) begin
      if (ctl.clear) begin
        found    <= 1'b0;
        vstart   <= '0;
        captured <= '0;
      end else begin
        captured <= value;
        if (ctl.set && !found) begin
          found  <= 1'b1;
          vstart <= ctl.start;
        end
      end
    end
  end

endmodule

@@ sv/firmware_header_tlv_extractor_unit.sv @@
// top level: byte-stream firmware header tag walker with result skid stage
//
// usage
//   input channel carries one image byte per transaction (data_byte) and
//   final_byte marking the last byte of the image. the header walk starts at
//   byte 8: first tag must be the total-length magic, then tag/length items
//   are chained. values of tags 1, 2 and 4 are captured by byte position.
//   output channel carries one result transaction per image, on its last
//   byte: status and the three captured values (zero unless status is ok).
//   the result is registered. throughput: one byte per cycle while in_stall
//   is low, set by the single registered pass through position compare and
//   the 32-bit step add. the block keeps taking bytes while a result waits;
//   a second result is held in a skid register, and only when that is also
//   full does in_stall rise. after the last byte all walk state returns to
//   reset for the next image. rst (synchronous) clears walk state and drops
//   out_valid.
module firmware_header_tlv_extractor_unit
  import fhte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] firmware_offset,
  output logic [31:0] rt_size,
  output logic [31:0] error_record_offset
);

  // walk state
  logic [31:0] pos;
  logic [32:0] item_start;
  logic [31:0] remaining;
  logic [63:0] header_shift;
  phase_t      phase;
  logic        magic_bad;

  logic [31:0] pos_next, remaining_next;
  logic [32:0] item_start_next;
  logic [63:0] header_shift_next;
  phase_t      phase_next;
  logic        magic_bad_next;

  // output stage
  logic    skid_valid;
  result_t out_res, skid_res, new_res;

  logic accept;
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // walk
  logic [31:0] lo, hi;
  logic [31:0] step_a, step_b, rem_a;
  logic [32:0] is_a;
  phase_t      ph_a;
  logic        hdr_done;
  logic [NUM_SLOTS-1:0] slot_set;
  logic [NUM_SLOTS-1:0] slot_found;
  logic [31:0] slot_value [NUM_SLOTS];
  logic [32:0] new_vstart;

  assign header_shift_next = {data_byte, header_shift[63:8]};
  assign lo = header_shift_next[31:0];
  assign hi = header_shift_next[63:32];
  assign step_a = HDR_BASE + lo;
  assign step_b = HDR_BASE + hi;

  always_comb begin
    // first item: magic check and total length
    ph_a           = phase;
    rem_a          = remaining;
    is_a           = item_start;
    magic_bad_next = magic_bad;
    if (phase == PH_FIRST) begin
      if (pos == POS_TAG0 && hi != HDR_MAGIC) begin
        magic_bad_next = 1'b1;
        ph_a           = PH_DONE;
      end else if (pos == POS_ITEM0) begin
        rem_a = hi;
        if (step_a != '0 && step_a < hi) begin
          rem_a = hi - step_a;
          is_a  = item_start + {1'b0, step_a};
          ph_a  = PH_WALK;
        end else begin
          ph_a = PH_DONE;
        end
      end
    end

    // later items, possibly completing in the same byte as the first
    hdr_done        = (ph_a == PH_WALK) && ({2'b00, pos} == {1'b0, is_a} + 34'd7);
    phase_next      = ph_a;
    remaining_next  = rem_a;
    item_start_next = is_a;
    new_vstart      = is_a + 33'd8;
    slot_set        = '0;
    if (hdr_done) begin
      slot_set[0] = (lo == TAG_FW_OFFSET);
      slot_set[1] = (lo == TAG_RT_SIZE);
      slot_set[2] = (lo == TAG_ERR_OFFSET);
      if (step_b != '0 && step_b < rem_a) begin
        remaining_next  = rem_a - step_b;
        item_start_next = is_a + {1'b0, step_b};
      end else begin
        phase_next = PH_DONE;
      end
    end

    pos_next = (pos == POS_MAX) ? POS_MAX : pos + 32'd1;
  end

  // value capture slots
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    slot_ctl_t ctl;
    assign ctl.en    = accept;
    assign ctl.set   = slot_set[k];
    assign ctl.clear = final_byte;
    assign ctl.start = new_vstart;
    fhte_slot u_slot (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .pos       (pos),
      .data_byte (data_byte),
      .found     (slot_found[k]),
      .value     (slot_value[k])
    );
  end

  // result of the last byte; found includes a tag completing on this byte
  always_comb begin
    logic all_found;
    all_found = &(slot_found | slot_set);
    new_res   = '0;
    if (magic_bad_next || pos_next < POS_MIN_OK) begin
      new_res.status = ST_BAD_MAGIC;
    end else if (!all_found) begin
      new_res.status = ST_TAG_MISSING;
    end else begin
      new_res.status              = ST_OK;
      new_res.firmware_offset     = slot_value[0];
      new_res.rt_size             = slot_value[1];
      new_res.error_record_offset = slot_value[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      item_start   <= {1'b0, HDR_BASE};
      remaining    <= '0;
      header_shift <= '0;
      phase        <= PH_FIRST;
      magic_bad    <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        pos          <= '0;
        item_start   <= {1'b0, HDR_BASE};
        remaining    <= '0;
        header_shift <= '0;
        phase        <= PH_FIRST;
        magic_bad    <= 1'b0;
      end else begin
        pos          <= pos_next;
        item_start   <= item_start_next;
        remaining    <= remaining_next;
        header_shift <= header_shift_next;
        phase        <= phase_next;
        magic_bad    <= magic_bad_next;
      end
    end
  end

  // output register plus skid
  logic produce;
  assign produce = accept && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && out_stall) begin
        // receiver holding: park a new result in the skid
        if (produce) begin
          skid_valid <= 1'b1;
          skid_res   <= new_res;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
        if (produce) begin
          out_res <= new_res;
        end
      end
    end
  end

  assign status              = out_res.status;
  assign firmware_offset     = out_res.firmware_offset;
  assign rt_size             = out_res.rt_size;
  assign error_record_offset = out_res.error_record_offset;

  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // a failed image never shows captured values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != ST_OK) |->
      (firmware_offset == '0 && rt_size == '0 && error_record_offset == '0))
    else $error("nonzero value with failing status");

  // a bad magic ends the walk
  a_magic_done: assert property (@(posedge clk) disable iff (rst)
    magic_bad |-> phase == PH_DONE)
    else $error("walk continues after bad magic");

  // stalled result transaction is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule
